// ===== rtl/elsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elsa_pkg: shared definitions for the evacuation LED strip animator
// Defaults, color constants, breathing sine table and the frame record.
// ----------------------------------------------------------------------------
package elsa_pkg;

  localparam int NUM_PIXELS_DEF    = 15;
  localparam int BREATH_PERIOD_DEF = 42;
  localparam int SINE_LEN          = 42;

  // breathing scale factors and offsets
  localparam logic [7:0] BLUE_SCALE    = 8'd200;
  localparam logic [7:0] BLUE_OFFSET   = 8'd20;
  localparam logic [7:0] ORANGE_R_SCALE  = 8'd200;
  localparam logic [7:0] ORANGE_R_OFFSET = 8'd30;
  localparam logic [7:0] ORANGE_G_SCALE  = 8'd100;
  localparam logic [7:0] ORANGE_G_OFFSET = 8'd10;

  localparam logic [7:0] FULL        = 8'd255;
  localparam logic [7:0] ORANGE_G    = 8'd165;
  localparam logic [7:0] CHASE_STEP  = 8'd80;

  // Q0.8 levels, round(128 + 128*sin(2*pi*k/42)) capped at 255
  localparam logic [7:0] SINE_ROM [SINE_LEN] = '{
    8'd128, 8'd147, 8'd166, 8'd184, 8'd200, 8'd215, 8'd228, 8'd239, 8'd247, 8'd253, 8'd255,
    8'd255, 8'd253, 8'd247, 8'd239, 8'd228, 8'd215, 8'd200, 8'd184, 8'd166, 8'd147,
    8'd128, 8'd109, 8'd90,  8'd72,  8'd56,  8'd41,  8'd28,  8'd17,  8'd9,   8'd3,   8'd0,
    8'd0,   8'd3,   8'd9,   8'd17,  8'd28,  8'd41,  8'd56,  8'd72,  8'd90,  8'd109
  };

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // everything the pixel generator needs for one frame (position kept apart,
  // its width follows NUM_PIXELS)
  typedef struct packed {
    rgb_t lamp;
    rgb_t strip;
    logic chase;
    logic forward;
  } frame_t;

endpackage

// ===== rtl/evacuation_led_strip_animator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evacuation_led_strip_animator: status lamp and strip animation per tick
// Takes one status tick, updates blink, breathing and chase state, and
// streams one RGB color per pixel, pixel 0 first.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields (tdata low bit up)                         | tlast
//  --------+-----+---------------------------------------------------+-------------
//  s_      | in  | calibrating, emergency, has_route,                | -
//          |     | potential_positive, node_id, next_hop,            |
//          |     | target_neighbor, neighbor_next_hop, 4 zero bits   |
//  m_      | out | pixel_index, red, green, blue, 4 zero bits        | last pixel
//
//  Rate: one tick yields NUM_PIXELS transfers, one per cycle while m_tready is high
//  or the output is empty; the pixel counter of the frame register steps them.
//  The next tick is taken in the cycle the last pixel of the current frame
//  moves into the output register, so frames run back to back.
//  Reset (rst, synchronous): chase head at 1, blink off, breathing phase 0,
//  no frame pending, output empty.
//  Stalls: m_tready low holds the output register and freezes the pixel
//  counter; s_tready stays low until the current frame is nearly done.
//
module evacuation_led_strip_animator
  import elsa_pkg::*;
#(
  parameter int NUM_PIXELS    = NUM_PIXELS_DEF,
  parameter int BREATH_PERIOD = BREATH_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] calibrating, [1] emergency, [2] has_route, [3] potential_positive,
  // [11:4] node_id, [19:12] next_hop, [27:20] target_neighbor,
  // [35:28] neighbor_next_hop, [39:36] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] pixel_index, [11:4] red, [19:12] green, [27:20] blue, [31:28] zero
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  localparam int PIX_W   = $clog2(NUM_PIXELS);
  localparam int CNT_W   = (PIX_W > 4) ? PIX_W : 4;
  localparam int PHASE_W = $clog2(BREATH_PERIOD);

  localparam logic [CNT_W-1:0]   RING     = CNT_W'(NUM_PIXELS - 1);
  localparam logic [CNT_W-1:0]   LAST_IDX = CNT_W'(NUM_PIXELS - 1);
  localparam logic [PHASE_W-1:0] PH_LAST  = PHASE_W'(BREATH_PERIOD - 1);

  // input fields
  logic       calibrating, emergency, has_route, potential_positive;
  logic [7:0] node_id, next_hop, target_neighbor, neighbor_next_hop;

  assign calibrating        = s_tdata[0];
  assign emergency          = s_tdata[1];
  assign has_route          = s_tdata[2];
  assign potential_positive = s_tdata[3];
  assign node_id            = s_tdata[11:4];
  assign next_hop           = s_tdata[19:12];
  assign target_neighbor    = s_tdata[27:20];
  assign neighbor_next_hop  = s_tdata[35:28];

  // animation state
  logic               blink_on, blink_on_next;
  logic [PHASE_W-1:0] breath_phase, breath_phase_next;
  logic [CNT_W-1:0]   chase_position, chase_position_next;

  // frame register and pixel counter
  frame_t           frame, frame_next;
  logic [CNT_W-1:0] frame_pos;
  logic             frame_valid;
  logic [CNT_W-1:0] cnt;

  logic s_xfer, out_load, frame_end;

  assign s_xfer    = s_tvalid && s_tready;
  assign out_load  = frame_valid && (!m_tvalid || m_tready);
  assign frame_end = out_load && (cnt == LAST_IDX);
  assign s_tready  = !frame_valid || frame_end;

  // breathing level per phase, index math folded at elaboration
  logic [7:0] level_tab [BREATH_PERIOD];

  for (genvar g = 0; g < BREATH_PERIOD; g++) begin : g_level
    localparam int K = ((g * SINE_LEN) / BREATH_PERIOD) % SINE_LEN;
    assign level_tab[g] = SINE_ROM[K];
  end

  logic [7:0]  level;
  logic [15:0] prod_b, prod_r, prod_g;

  assign blink_on_next     = ~blink_on;
  assign breath_phase_next = (breath_phase == PH_LAST) ? '0 : breath_phase + 1'b1;
  assign level             = level_tab[breath_phase_next];
  assign prod_b            = 16'(level) * 16'(BLUE_SCALE);
  assign prod_r            = 16'(level) * 16'(ORANGE_R_SCALE);
  assign prod_g            = 16'(level) * 16'(ORANGE_G_SCALE);

  // per-tick decisions
  always_comb begin
    frame_next = '0;

    // status lamp, priority: calibrating, emergency, route, no route
    if (calibrating) begin
      frame_next.lamp.b = FULL;
    end else if (emergency) begin
      frame_next.lamp.r = blink_on_next ? FULL : 8'd0;
    end else if (has_route) begin
      frame_next.lamp.r = potential_positive ? FULL : 8'd0;
      frame_next.lamp.g = FULL;
    end else begin
      frame_next.lamp.r = FULL;
      frame_next.lamp.g = ORANGE_G;
    end

    // strip
    if (calibrating) begin
      frame_next.strip.b = prod_b[15:8] + BLUE_OFFSET;
    end else if (emergency) begin
      frame_next.strip.r = blink_on_next ? FULL : 8'd0;
    end else if (!has_route) begin
      frame_next.strip.r = prod_r[15:8] + ORANGE_R_OFFSET;
      frame_next.strip.g = prod_g[15:8] + ORANGE_G_OFFSET;
    end else if (node_id == 8'd0) begin
      frame_next.strip.g = FULL;           // exit node
    end else if (next_hop == target_neighbor) begin
      frame_next.chase   = 1'b1;
      frame_next.forward = 1'b1;
    end else if (neighbor_next_hop == node_id) begin
      frame_next.chase   = 1'b1;
      frame_next.forward = 1'b0;
    end
  end

  // head moves on the ring 1..NUM_PIXELS-1, holds without a chase
  always_comb begin
    chase_position_next = chase_position;
    if (frame_next.chase) begin
      if (frame_next.forward) begin
        chase_position_next = (chase_position == RING) ? CNT_W'(1) : chase_position + 1'b1;
      end else begin
        chase_position_next = (chase_position == CNT_W'(1)) ? RING : chase_position - 1'b1;
      end
    end
  end

  // pixel generator
  rgb_t             pix;
  logic [CNT_W-1:0] tail_dist;

  always_comb begin
    if (frame.forward) begin
      tail_dist = (frame_pos >= cnt) ? frame_pos - cnt : frame_pos + RING - cnt;
    end else begin
      tail_dist = (cnt >= frame_pos) ? cnt - frame_pos : cnt + RING - frame_pos;
    end

    if (cnt == '0) begin
      pix = frame.lamp;
    end else if (frame.chase) begin
      pix = '0;
      if (tail_dist == CNT_W'(0)) begin
        pix.g = FULL;
      end else if (tail_dist == CNT_W'(1)) begin
        pix.g = FULL - CHASE_STEP;
      end else if (tail_dist == CNT_W'(2)) begin
        pix.g = FULL - CHASE_STEP - CHASE_STEP;
      end
    end else begin
      pix = frame.strip;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_on       <= 1'b0;
      breath_phase   <= '0;
      chase_position <= CNT_W'(1);
      frame_valid    <= 1'b0;
      cnt            <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (s_xfer) begin
        blink_on       <= blink_on_next;
        breath_phase   <= breath_phase_next;
        chase_position <= chase_position_next;
        frame_valid    <= 1'b1;
        cnt            <= '0;
      end else if (frame_end) begin
        frame_valid <= 1'b0;
      end else if (out_load) begin
        cnt <= cnt + 1'b1;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      frame     <= frame_next;
      frame_pos <= chase_position_next;
    end
    if (out_load) begin
      m_tdata <= {4'd0, pix.b, pix.g, pix.r, cnt[3:0]};
      m_tlast <= (cnt == LAST_IDX);
    end
  end

  // checks
  a_accept_starts_frame : assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> frame_valid && (cnt == '0))
    else $error("accepted tick did not start a frame at pixel 0");

  a_ready_only_at_end : assert property (@(posedge clk) disable iff (rst)
    (s_tready && frame_valid) |-> (out_load && (cnt == LAST_IDX)))
    else $error("tick taken while a frame is still in progress");

  a_head_on_ring : assert property (@(posedge clk) disable iff (rst)
    (chase_position >= CNT_W'(1)) && (chase_position <= RING))
    else $error("chase head left the ring");

  a_frame_head_on_ring : assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (frame_pos >= CNT_W'(1)) && (frame_pos <= RING))
    else $error("frame chase head left the ring");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (cnt <= LAST_IDX))
    else $error("pixel counter past the last pixel");

endmodule
